@@ sv/hkvo_pkg.sv @@
package hkvo_pkg;

    localparam int MAX_TARGETS_DEF = 12;
    localparam int DIST_BITS_DEF   = 24;

    // Configuration port: data as wide as the widest register.
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_EXIT     = 1'd1;

    // Memory read issued this cycle; the datapath consumes the data in the next cycle.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DP,
        OP_FIN,
        OP_LD_START,
        OP_LD_PAIR
    } t_op;

    typedef struct packed {
        t_op  op;
        logic solve_init;
        logic acc_init;
        logic cost_wr;
        logic fin_init;
        logic gr_init;
        logic scan_init;
        logic scan_step;
        logic pick;
        logic bt_init;
        logic bt_push;
        logic bt_next;
        logic emit_init;
        logic emit_step;
    } t_cmd;

    typedef struct packed {
        logic have_end;
        logic got;
        logic bt_single;
        logic emit_done;
    } t_sts;

endpackage

@@ sv/hkvo_ctrl.sv @@
module hkvo_ctrl #(
    parameter int MAX_TARGETS = hkvo_pkg::MAX_TARGETS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_last_load,
    input  logic [$clog2(MAX_TARGETS+1)-1:0]   i_n,
    input  hkvo_pkg::t_sts                     i_sts,
    output logic                               o_in_ready,
    output hkvo_pkg::t_cmd                     o_cmd,
    output logic [MAX_TARGETS-1:0]             o_mask,
    output logic [$clog2(MAX_TARGETS)-1:0]     o_i,
    output logic [$clog2(MAX_TARGETS)-1:0]     o_j
);
    localparam int MT = MAX_TARGETS;
    localparam int TW = $clog2(MAX_TARGETS);
    localparam int IW = $clog2(MAX_TARGETS+1);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_DP_INIT  = 16'h0002,
        S_DP_RD    = 16'h0004,
        S_DP_LAST  = 16'h0008,
        S_DP_WR    = 16'h0010,
        S_FIN_RD   = 16'h0020,
        S_FIN_LAST = 16'h0040,
        S_FIN_DEC  = 16'h0080,
        S_BT_PUSH  = 16'h0100,
        S_BT_NEXT  = 16'h0200,
        S_GR_LD    = 16'h0400,
        S_GR_DRAIN = 16'h0800,
        S_GR_SCAN  = 16'h1000,
        S_GR_PICK  = 16'h2000,
        S_GR_UPD   = 16'h4000,
        S_EMIT     = 16'h8000
    } t_state;

    t_state          r_state, n_state;
    logic [MT-1:0]   r_mask, n_mask;
    logic [TW-1:0]   r_i, n_i;
    logic [TW-1:0]   r_j, n_j;
    logic [MT-1:0]   full;
    logic [MT-1:0]   jbit;
    logic [TW-1:0]   nm1;
    logic            i_last;
    logic            adv;

    assign full   = ~({MT{1'b1}} << i_n);
    assign jbit   = MT'(1) << r_j;
    assign nm1    = TW'(i_n - IW'(1));
    assign i_last = (r_i == nm1);

    assign o_mask = r_mask;
    assign o_i    = r_i;
    assign o_j    = r_j;

    always_comb begin
        n_state    = r_state;
        n_mask     = r_mask;
        n_i        = r_i;
        n_j        = r_j;
        o_cmd      = '0;
        o_cmd.op   = hkvo_pkg::OP_NONE;
        o_in_ready = 1'b0;
        adv        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_last_load) begin
                    o_cmd.solve_init = 1'b1;
                    n_mask = MT'(1);
                    n_j    = '0;
                    if (i_n == '0) begin
                        o_cmd.emit_init = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_DP_INIT;
                    end
                end
            end
            S_DP_INIT: begin
                if (!r_mask[r_j]) begin
                    adv = 1'b1;
                end else begin
                    o_cmd.acc_init = 1'b1;
                    n_i = '0;
                    n_state = (r_mask == jbit) ? S_DP_LAST : S_DP_RD;
                end
            end
            S_DP_RD: begin
                o_cmd.op = (r_mask[r_i] && r_i != r_j) ? hkvo_pkg::OP_DP : hkvo_pkg::OP_NONE;
                n_i = r_i + TW'(1);
                if (i_last) n_state = S_DP_LAST;
            end
            S_DP_LAST: n_state = S_DP_WR;
            S_DP_WR: begin
                o_cmd.cost_wr = 1'b1;
                adv = 1'b1;
            end
            S_FIN_RD: begin
                o_cmd.op = hkvo_pkg::OP_FIN;
                n_i = r_i + TW'(1);
                if (i_last) n_state = S_FIN_LAST;
            end
            S_FIN_LAST: n_state = S_FIN_DEC;
            S_FIN_DEC: begin
                if (i_sts.have_end) begin
                    o_cmd.bt_init = 1'b1;
                    n_state = S_BT_PUSH;
                end else begin
                    o_cmd.gr_init = 1'b1;
                    n_i = '0;
                    n_state = S_GR_LD;
                end
            end
            S_BT_PUSH: begin
                o_cmd.bt_push = 1'b1;
                if (i_sts.bt_single) begin
                    o_cmd.emit_init = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_BT_NEXT;
                end
            end
            S_BT_NEXT: begin
                o_cmd.bt_next = 1'b1;
                n_state = S_BT_PUSH;
            end
            S_GR_LD: begin
                o_cmd.op = hkvo_pkg::OP_LD_START;
                n_i = r_i + TW'(1);
                if (i_last) n_state = S_GR_DRAIN;
            end
            S_GR_DRAIN: begin
                o_cmd.scan_init = 1'b1;
                n_i = '0;
                n_state = S_GR_SCAN;
            end
            S_GR_SCAN: begin
                o_cmd.scan_step = 1'b1;
                n_i = r_i + TW'(1);
                if (i_last) n_state = S_GR_PICK;
            end
            S_GR_PICK: begin
                if (i_sts.got) begin
                    o_cmd.pick = 1'b1;
                    n_i = '0;
                    n_state = S_GR_UPD;
                end else begin
                    o_cmd.emit_init = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_GR_UPD: begin
                o_cmd.op = hkvo_pkg::OP_LD_PAIR;
                n_i = r_i + TW'(1);
                if (i_last) n_state = S_GR_DRAIN;
            end
            S_EMIT: begin
                o_cmd.emit_step = 1'b1;
                if (i_sts.emit_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // Step to the next end target, then to the next subset; after the full
        // subset the final pass over tour ends begins.
        if (adv) begin
            if (r_j == nm1) begin
                n_j = '0;
                if (r_mask == full) begin
                    o_cmd.fin_init = 1'b1;
                    n_i = '0;
                    n_state = S_FIN_RD;
                end else begin
                    n_mask = r_mask + MT'(1);
                    n_state = S_DP_INIT;
                end
            end else begin
                n_j = r_j + TW'(1);
                n_state = S_DP_INIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mask  <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_mask  <= n_mask;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

endmodule

@@ sv/hkvo_dp.sv @@
module hkvo_dp #(
    parameter int MAX_TARGETS = hkvo_pkg::MAX_TARGETS_DEF,
    parameter int DIST_BITS   = hkvo_pkg::DIST_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_ld_we,
    input  logic [$clog2(MAX_TARGETS+1)-1:0]   i_from_index,
    input  logic [$clog2(MAX_TARGETS+1)-1:0]   i_to_index,
    input  logic [DIST_BITS-1:0]               i_distance,
    input  logic                               i_has_exit,
    input  hkvo_pkg::t_cmd                     i_cmd,
    input  logic [MAX_TARGETS-1:0]             i_mask,
    input  logic [$clog2(MAX_TARGETS)-1:0]     i_i,
    input  logic [$clog2(MAX_TARGETS)-1:0]     i_j,
    output hkvo_pkg::t_sts                     o_sts,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [$clog2(MAX_TARGETS)-1:0]     o_target_index,
    output logic                               o_found,
    output logic                               o_greedy_used,
    output logic                               o_last_of_order
);
    localparam int MT = MAX_TARGETS;
    localparam int TW = $clog2(MAX_TARGETS);
    localparam int IW = $clog2(MAX_TARGETS+1);
    localparam int DW = DIST_BITS;
    localparam logic [DW-1:0] DMAX = '1;

    function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, DMAX}) ? DMAX : s[DW-1:0];
    endfunction

    // Distance stores and the subset cost table.
    logic [DW-1:0] pair_mem  [0:2**(2*TW)-1];
    logic [DW-1:0] start_mem [0:2**TW-1];
    logic [DW-1:0] exit_mem  [0:2**TW-1];
    logic [DW-1:0] cost_mem  [0:2**(MT+TW)-1];
    logic [TW-1:0] par_mem   [0:2**(MT+TW)-1];

    logic [DW-1:0] r_pair_q, r_start_q, r_exit_q, r_cost_q;
    logic [TW-1:0] r_par_q;

    hkvo_pkg::t_op r_d_op;
    logic [TW-1:0] r_d_i;

    logic [DW-1:0] r_acc, r_best, r_cb;
    logic [TW-1:0] r_par, r_end, r_ci, r_cur;
    logic          r_have, r_got, r_greedy;
    logic [MT-1:0] r_visited, r_bt_mask;
    logic [DW-1:0] r_dcur  [0:MT-1];
    logic [TW-1:0] r_order [0:MT-1];
    logic [IW-1:0] r_len, r_e;

    logic              from_t, to_t, from_s, to_x;
    logic [MT-1:0]     jbit;
    logic [2*TW-1:0]   pair_ra;
    logic [TW-1:0]     start_ra;
    logic [MT+TW-1:0]  cost_ra, cost_wa;
    logic [MT-1:0]     cost_ra_mask;
    logic              single;
    logic [DW-1:0]     cand, fin_c;
    logic              scan_hit;
    logic [IW-1:0]     cnt;
    logic [TW-1:0]     sel;
    logic              emit_done, emit_ld;

    assign from_t = i_from_index < IW'(MT);
    assign to_t   = i_to_index < IW'(MT);
    assign from_s = i_from_index == IW'(MT);
    assign to_x   = i_to_index == IW'(MT);

    assign jbit         = MT'(1) << i_j;
    assign single       = (i_mask == jbit);
    assign pair_ra      = (i_cmd.op == hkvo_pkg::OP_LD_PAIR) ? {r_ci, i_i} : {i_i, i_j};
    assign start_ra     = (i_cmd.op == hkvo_pkg::OP_LD_START) ? i_i : i_j;
    assign cost_ra_mask = (i_cmd.op == hkvo_pkg::OP_FIN) ? i_mask : (i_mask & ~jbit);
    assign cost_ra      = {cost_ra_mask, i_i};
    assign cost_wa      = {i_mask, i_j};

    always_ff @(posedge i_clk) begin
        if (i_ld_we) begin
            if (from_t && to_t) begin
                pair_mem[{i_from_index[TW-1:0], i_to_index[TW-1:0]}] <= i_distance;
            end else if (from_s && to_t) begin
                start_mem[i_to_index[TW-1:0]] <= i_distance;
            end else if (from_t && to_x) begin
                exit_mem[i_from_index[TW-1:0]] <= i_distance;
            end
        end
        r_pair_q  <= pair_mem[pair_ra];
        r_start_q <= start_mem[start_ra];
        r_exit_q  <= exit_mem[i_i];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cost_wr) begin
            cost_mem[cost_wa] <= single ? r_start_q : r_acc;
            par_mem[cost_wa]  <= single ? '0 : r_par;
        end
        r_cost_q <= cost_mem[cost_ra];
        r_par_q  <= par_mem[{r_bt_mask, r_cur}];
    end

    assign cand     = sat_add(r_cost_q, r_pair_q);
    assign fin_c    = i_has_exit ? sat_add(r_cost_q, r_exit_q) : r_cost_q;
    assign scan_hit = !r_visited[i_i] && (r_dcur[i_i] < r_cb);

    assign cnt       = (r_len == '0) ? IW'(1) : r_len;
    assign sel       = r_greedy ? r_e[TW-1:0] : TW'(r_len - r_e - IW'(1));
    assign emit_done = (r_e == cnt);
    assign emit_ld   = i_cmd.emit_step && !emit_done && (!o_out_valid || i_out_ready);

    assign o_sts.have_end  = r_have;
    assign o_sts.got       = r_got;
    assign o_sts.bt_single = (r_bt_mask == (MT'(1) << r_cur));
    assign o_sts.emit_done = emit_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_op      <= hkvo_pkg::OP_NONE;
            r_have      <= 1'b0;
            r_got       <= 1'b0;
            r_greedy    <= 1'b0;
            r_visited   <= '0;
            r_len       <= '0;
            r_e         <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_d_op <= i_cmd.op;
            r_d_i  <= i_i;

            // Consume the data of the read issued in the previous cycle.
            case (r_d_op)
                hkvo_pkg::OP_DP: begin
                    if (cand < r_acc) begin
                        r_acc <= cand;
                        r_par <= r_d_i;
                    end
                end
                hkvo_pkg::OP_FIN: begin
                    if (r_cost_q != DMAX && fin_c < r_best) begin
                        r_best <= fin_c;
                        r_end  <= r_d_i;
                        r_have <= 1'b1;
                    end
                end
                hkvo_pkg::OP_LD_START: r_dcur[r_d_i] <= r_start_q;
                hkvo_pkg::OP_LD_PAIR: begin
                    if (!r_visited[r_d_i]) r_dcur[r_d_i] <= r_pair_q;
                end
                default: ;
            endcase

            if (i_cmd.solve_init) begin
                r_len    <= '0;
                r_greedy <= 1'b0;
            end
            if (i_cmd.acc_init) begin
                r_acc <= DMAX;
                r_par <= '0;
            end
            if (i_cmd.fin_init) begin
                r_best <= DMAX;
                r_have <= 1'b0;
            end
            if (i_cmd.bt_init) begin
                r_cur     <= r_end;
                r_bt_mask <= i_mask;
            end
            if (i_cmd.bt_push) begin
                r_order[r_len[TW-1:0]] <= r_cur;
                r_len <= r_len + IW'(1);
            end
            if (i_cmd.bt_next) begin
                r_bt_mask <= r_bt_mask & ~(MT'(1) << r_cur);
                r_cur     <= r_par_q;
            end
            if (i_cmd.gr_init) begin
                r_visited <= '0;
                r_len     <= '0;
                r_greedy  <= 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_cb  <= DMAX;
                r_got <= 1'b0;
            end
            if (i_cmd.scan_step && scan_hit) begin
                r_cb  <= r_dcur[i_i];
                r_ci  <= i_i;
                r_got <= 1'b1;
            end
            if (i_cmd.pick) begin
                r_visited[r_ci]        <= 1'b1;
                r_order[r_len[TW-1:0]] <= r_ci;
                r_len                  <= r_len + IW'(1);
            end
            if (i_cmd.emit_init) r_e <= '0;

            if (emit_ld) begin
                o_out_valid     <= 1'b1;
                r_e             <= r_e + IW'(1);
                o_greedy_used   <= r_greedy;
                o_last_of_order <= (r_e == cnt - IW'(1));
                // An empty order gives a single result that names no target.
                if (r_len == '0) begin
                    o_target_index <= '0;
                    o_found        <= 1'b0;
                end else begin
                    o_target_index <= r_order[sel];
                    o_found        <= 1'b1;
                end
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ sv/held_karp_visit_order.sv @@
// Exact visit-order planner for up to MAX_TARGETS targets.
// Input channel (i_in_valid / o_in_ready): one distance load per request,
// start-to-target (from = MAX_TARGETS), target-to-target, or target-to-exit
// (to = MAX_TARGETS). Loads are taken one per cycle while the block is idle.
// The request with i_last_load set starts a solve over target_count targets.
// The solve walks every subset of n targets with one end target at a time,
// one predecessor per cycle through the cost table, then picks the tour end
// from the full subset and backtracks through the stored predecessors.
// Without a complete tour, a nearest-neighbour fallback loads the start
// distances and then scans and reloads distances for each pick. No load is
// accepted during a solve.
// Output channel (o_out_valid / i_out_ready): the visit order, one result per
// cycle from an output register; a stalled receiver holds the current result
// and the rest wait. After the last result is in the output register, new
// loads are accepted again. Configuration writes take effect at once; the user
// makes them only while no solve or result is pending, unchecked by the block.
// Reset clears control state and the output register, and sets target_count
// to 1 and has_exit to 0; the distance stores and cost table are not cleared.
module held_karp_visit_order #(
    parameter int MAX_TARGETS = hkvo_pkg::MAX_TARGETS_DEF,
    parameter int DIST_BITS   = hkvo_pkg::DIST_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [hkvo_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hkvo_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [$clog2(MAX_TARGETS+1)-1:0]     i_from_index,
    input  logic [$clog2(MAX_TARGETS+1)-1:0]     i_to_index,
    input  logic [DIST_BITS-1:0]                 i_distance,
    input  logic                                 i_last_load,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [$clog2(MAX_TARGETS)-1:0]       o_target_index,
    output logic                                 o_found,
    output logic                                 o_greedy_used,
    output logic                                 o_last_of_order
);
    localparam int MT = MAX_TARGETS;
    localparam int TW = $clog2(MAX_TARGETS);
    localparam int IW = $clog2(MAX_TARGETS+1);

    logic [hkvo_pkg::CFG_DATA_W-1:0] r_count;
    logic                            r_has_exit;
    logic [IW-1:0]                   n_eff;
    logic                            ld_we;
    hkvo_pkg::t_cmd                  cmd;
    hkvo_pkg::t_sts                  sts;
    logic [MT-1:0]                   mask;
    logic [TW-1:0]                   idx_i, idx_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= hkvo_pkg::CFG_DATA_W'(1);
            r_has_exit <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hkvo_pkg::REG_TARGET_COUNT: r_count    <= i_cfg_data;
                hkvo_pkg::REG_HAS_EXIT:     r_has_exit <= i_cfg_data[0];
            endcase
        end
    end

    assign n_eff = (int'(r_count) > MT) ? IW'(MT) : IW'(r_count);
    assign ld_we = i_in_valid && o_in_ready;

    hkvo_ctrl #(
        .MAX_TARGETS(MAX_TARGETS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_load (i_last_load),
        .i_n         (n_eff),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd),
        .o_mask      (mask),
        .o_i         (idx_i),
        .o_j         (idx_j)
    );

    hkvo_dp #(
        .MAX_TARGETS(MAX_TARGETS),
        .DIST_BITS  (DIST_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ld_we         (ld_we),
        .i_from_index    (i_from_index),
        .i_to_index      (i_to_index),
        .i_distance      (i_distance),
        .i_has_exit      (r_has_exit),
        .i_cmd           (cmd),
        .i_mask          (mask),
        .i_i             (idx_i),
        .i_j             (idx_j),
        .o_sts           (sts),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_target_index  (o_target_index),
        .o_found         (o_found),
        .o_greedy_used   (o_greedy_used),
        .o_last_of_order (o_last_of_order)
    );

    // A result that names no target is always the whole order.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_last_of_order)
        else $error("empty order result without last_of_order");

    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_target_index == '0)
        else $error("empty order result with nonzero target index");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

@@ tb/held_karp_visit_order_test.sv @@
module held_karp_visit_order_test;

    localparam int NT       = hkvo_pkg::MAX_TARGETS_DEF;
    localparam int DB       = hkvo_pkg::DIST_BITS_DEF;
    localparam int CW       = hkvo_pkg::CFG_DATA_W;
    localparam int XW       = hkvo_pkg::CFG_IDX_W;
    localparam logic [DB-1:0] UNREACH = {DB{1'b1}};
    localparam int STALL_LIMIT = 3000000;

    typedef struct packed {
        logic [3:0]    from_i;
        logic [3:0]    to_i;
        logic [DB-1:0] walk_len;
        logic          last;
    } t_load;

    typedef struct packed {
        logic [3:0] idx;
        logic       found;
        logic       greedy;
        logic       last;
    } t_visit;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [XW-1:0] i_cfg_index;
    logic [CW-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    logic [3:0]    i_from_index;
    logic [3:0]    i_to_index;
    logic [DB-1:0] i_distance;
    logic i_last_load;
    logic o_out_valid;
    logic i_out_ready;
    logic [3:0] o_target_index;
    logic o_found;
    logic o_greedy_used;
    logic o_last_of_order;

    held_karp_visit_order i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_from_index(i_from_index), .i_to_index(i_to_index),
        .i_distance(i_distance), .i_last_load(i_last_load),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_target_index(o_target_index), .o_found(o_found),
        .o_greedy_used(o_greedy_used), .o_last_of_order(o_last_of_order)
    );

    // Shadow copy of the block's stores and registers.
    logic [DB-1:0] dist_pair [NT][NT];
    logic [DB-1:0] dist_start [NT];
    logic [DB-1:0] dist_exit [NT];
    logic [DB-1:0] cost_tab [1<<NT][NT];
    logic [3:0]    link_tab [1<<NT][NT];
    logic [3:0]    cnt_reg;
    logic          exit_reg;

    t_load  load_queue[$];
    t_visit visit_queue[$];
    t_load  cur_load;
    int     errors;
    int     loads_pushed;
    int     stall_cycles;
    bit     no_idle;
    bit     held_once;
    int     hold_cnt;

    function automatic logic [DB-1:0] sat_sum(logic [DB-1:0] a, logic [DB-1:0] b);
        logic [DB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, UNREACH}) ? UNREACH : s[DB-1:0];
    endfunction

    task automatic push_visit(int idx, bit found, bit greedy, bit last);
        t_visit v;
        v.idx = idx[3:0];
        v.found = found;
        v.greedy = greedy;
        v.last = last;
        visit_queue = {visit_queue, v};
    endtask

    task automatic plan_visit_order();
        int n, full, m, i, j, len, cur, p, step, ci, best_end, nm;
        logic [DB-1:0] c, nd, best, cb;
        logic [DB-1:0] dcur [NT];
        int order [NT];
        bit have_end, got;
        logic [NT-1:0] seen;
        n = (cnt_reg > NT) ? NT : cnt_reg;
        len = 0;
        best = UNREACH;
        best_end = 0;
        have_end = 0;
        if (n == 0) begin
            push_visit(0, 0, 0, 1);
            return;
        end
        full = (1 << n) - 1;
        for (m = 0; m <= full; m++)
            for (i = 0; i < n; i++) begin
                cost_tab[m][i] = UNREACH;
                link_tab[m][i] = 0;
            end
        for (i = 0; i < n; i++) cost_tab[1 << i][i] = dist_start[i];
        for (m = 1; m <= full; m++)
            for (i = 0; i < n; i++) begin
                c = cost_tab[m][i];
                if (!m[i] || c == UNREACH) continue;
                for (j = 0; j < n; j++) begin
                    if (m[j]) continue;
                    nd = sat_sum(c, dist_pair[i][j]);
                    nm = m | (1 << j);
                    if (nd < cost_tab[nm][j]) begin
                        cost_tab[nm][j] = nd;
                        link_tab[nm][j] = i[3:0];
                    end
                end
            end
        for (i = 0; i < n; i++) begin
            c = cost_tab[full][i];
            if (c == UNREACH) continue;
            if (exit_reg) c = sat_sum(c, dist_exit[i]);
            if (c < best) begin
                best = c;
                best_end = i;
                have_end = 1;
            end
        end
        if (have_end) begin
            cur = best_end;
            m = full;
            while (len < n) begin
                order[len++] = cur;
                if (m == (1 << cur)) break;
                p = link_tab[m][cur] % NT;
                m = m & ~(1 << cur);
                cur = p;
            end
            for (i = 0; i < len; i++) push_visit(order[len-1-i], 1, 0, i == len - 1);
            return;
        end
        // No complete tour: nearest-neighbour fallback.
        seen = '0;
        for (i = 0; i < n; i++) dcur[i] = dist_start[i];
        for (step = 0; step < n; step++) begin
            cb = UNREACH;
            ci = 0;
            got = 0;
            for (i = 0; i < n; i++)
                if (!seen[i] && dcur[i] < cb) begin
                    cb = dcur[i];
                    ci = i;
                    got = 1;
                end
            if (!got) break;
            seen[ci] = 1'b1;
            order[len++] = ci;
            for (i = 0; i < n; i++) if (!seen[i]) dcur[i] = dist_pair[ci][i];
        end
        if (len == 0) push_visit(0, 0, 1, 1);
        else for (i = 0; i < len; i++) push_visit(order[i], 1, 1, i == len - 1);
    endtask

    task automatic take_load(t_load ld);
        if (ld.from_i < NT && ld.to_i < NT) dist_pair[ld.from_i][ld.to_i] = ld.walk_len;
        else if (ld.from_i == NT && ld.to_i < NT) dist_start[ld.to_i] = ld.walk_len;
        else if (ld.from_i < NT && ld.to_i == NT) dist_exit[ld.from_i] = ld.walk_len;
        if (ld.last) plan_visit_order();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) take_load(cur_load);
            if (!i_in_valid || o_in_ready) begin
                if (load_queue.size() > 0 && (no_idle || $urandom_range(0, 99) >= 16)) begin
                    cur_load = load_queue.pop_front();
                    i_from_index <= cur_load.from_i;
                    i_to_index   <= cur_load.to_i;
                    i_distance   <= cur_load.walk_len;
                    i_last_load  <= cur_load.last;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge i_clk) begin
        t_visit exp_v;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (visit_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: idx %0d found %0b greedy %0b last %0b",
                                 o_target_index, o_found, o_greedy_used, o_last_of_order);
                end else begin
                    exp_v = visit_queue.pop_front();
                    if (o_target_index !== exp_v.idx || o_found !== exp_v.found ||
                        o_greedy_used !== exp_v.greedy || o_last_of_order !== exp_v.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                                     exp_v.idx, exp_v.found, exp_v.greedy, exp_v.last,
                                     o_target_index, o_found, o_greedy_used, o_last_of_order);
                    end
                end
            end
            // Hold the receiver off once while more requests are waiting.
            if (!held_once && o_out_valid && load_queue.size() > 0) begin
                held_once = 1;
                hold_cnt = 600;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= no_idle || $urandom_range(0, 99) >= 16;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [DB-1:0] pick_dist(int unreach_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < unreach_pct) return UNREACH;
        r = $urandom_range(0, 9);
        if (r == 0) return UNREACH - DB'($urandom_range(0, 3));
        if (r <= 2) return DB'($urandom());
        return DB'($urandom_range(0, 4095));
    endfunction

    task automatic push_load(int f, int t, logic [DB-1:0] d, bit last);
        t_load ld;
        ld.from_i = f[3:0];
        ld.to_i = t[3:0];
        ld.walk_len = d;
        ld.last = last;
        load_queue = {load_queue, ld};
        loads_pushed++;
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (load_queue.size() > 0 || i_in_valid || visit_queue.size() > 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [XW-1:0] idx, logic [CW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == hkvo_pkg::REG_TARGET_COUNT) cnt_reg = val;
        else exit_reg = val[0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_group(int n, int unreach_pct);
        int k, f, t;
        k = $urandom_range(8, 18);
        repeat (k) begin
            if ($urandom_range(0, 9) == 0) begin
                f = $urandom_range(0, 15);
                t = $urandom_range(NT, 15);
            end else begin
                f = $urandom_range(0, n);
                t = $urandom_range(0, n);
                if (f == n) f = NT;
                if (t == n) t = NT;
            end
            push_load(f, t, pick_dist(unreach_pct), 0);
        end
        push_load($urandom_range(0, 15), $urandom_range(0, 15), pick_dist(unreach_pct), 1);
    endtask

    initial begin
        int i, j, n, pct;
        errors = 0;
        loads_pushed = 0;
        stall_cycles = 0;
        no_idle = 0;
        held_once = 0;
        hold_cnt = 0;
        cnt_reg = 1;
        exit_reg = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_from_index = '0;
        i_to_index = '0;
        i_distance = '0;
        i_last_load = 1'b0;
        i_out_ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill every distance so that no solve reads an unwritten entry.
        for (i = 0; i < NT; i++) push_load(NT, i, DB'($urandom_range(1, 4095)), 0);
        for (i = 0; i < NT; i++) push_load(i, NT, DB'($urandom_range(0, 4095)), 0);
        for (i = 0; i < NT; i++)
            for (j = 0; j < NT; j++) push_load(i, j, pick_dist(5), 0);
        wait_drained();

        // Default count of one, with the ignored start-to-exit load solving.
        push_load(NT, NT, UNREACH, 1);
        wait_drained();
        write_reg(hkvo_pkg::REG_TARGET_COUNT, CW'(0));
        push_load(15, 15, 24'h0, 1);
        wait_drained();
        // Exit costs, self distance, extreme distances and saturating sums.
        write_reg(hkvo_pkg::REG_TARGET_COUNT, CW'(3));
        write_reg(hkvo_pkg::REG_HAS_EXIT, CW'(1));
        push_load(1, 1, 24'h0, 0);
        push_load(NT, 0, UNREACH - DB'(1), 0);
        push_load(0, 1, 24'h000002, 0);
        push_load(13, 2, 24'h5, 0);
        push_load(2, 14, 24'h5, 0);
        push_load(1, NT, UNREACH, 1);
        wait_drained();
        // Nothing reachable from the start.
        write_reg(hkvo_pkg::REG_TARGET_COUNT, CW'(2));
        write_reg(hkvo_pkg::REG_HAS_EXIT, CW'(0));
        push_load(NT, 0, UNREACH, 0);
        push_load(NT, 1, UNREACH, 1);
        wait_drained();
        // Greedy gets stuck after one target.
        write_reg(hkvo_pkg::REG_TARGET_COUNT, CW'(3));
        push_load(NT, 0, 24'h000010, 0);
        push_load(NT, 2, UNREACH, 0);
        push_load(0, 1, UNREACH, 0);
        push_load(0, 2, UNREACH, 1);
        wait_drained();
        // Count above the maximum saturates; this is the one full-size solve.
        write_reg(hkvo_pkg::REG_TARGET_COUNT, CW'(15));
        push_load(NT, 0, 24'h000001, 1);
        wait_drained();

        i = 0;
        while (loads_pushed < 460) begin
            if (i == 3) n = 0;
            else if (i % 5 == 4) n = $urandom_range(6, 8);
            else n = $urandom_range(1, 5);
            no_idle = (i >= 6 && i < 9);
            pct = ($urandom_range(0, 3) == 0) ? 60 : 8;
            write_reg(hkvo_pkg::REG_TARGET_COUNT, CW'(n));
            write_reg(hkvo_pkg::REG_HAS_EXIT, CW'($urandom_range(0, 1)));
            random_group(n, pct);
            if (i % 3 == 1) random_group(n, pct);
            wait_drained();
            i++;
        end
        no_idle = 0;
        wait_drained();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
